// ===== design/igfr_pkg.sv =====
// shared types and constants for the idle-gap frame receiver
// no dependencies

package igfr_pkg;

  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned IDLE_W           = 8;
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 8'd10;
  localparam logic [IDLE_W-1:0] IDLE_MAX         = 8'd255;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_FETCH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_STREAM = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic take_tick;
    logic stream_en;
    logic stream_done;
    logic no_frame;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_ready;
    logic last_idx;
  } status_t;

endpackage

// ===== design/igfr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module igfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/igfr_ctrl.sv =====
// controller state machine: transaction accept, op decode, frame streaming
// depends on igfr_pkg

module igfr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_operation,
  input  igfr_pkg::status_t status,
  output igfr_pkg::cmd_t   cmd,
  output logic             busy
);

  import igfr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;
  op_t    op;

  assign accept = start && (state_r == ST_IDLE);
  assign op     = op_t'(in_operation);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && op == OP_FETCH && status.frame_ready) begin
          state_nxt = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (status.last_idx) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.take_byte = accept && op == OP_BYTE;
        cmd.take_tick = accept && op == OP_TICK;
        cmd.no_frame  = accept && op == OP_FETCH && !status.frame_ready;
      end
      ST_STREAM: begin
        busy            = 1'b1;
        cmd.stream_en   = 1'b1;
        cmd.stream_done = status.last_idx;
      end
      default: begin
        cmd  = '0;
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/igfr_dp.sv =====
// datapath: frame store, fill count, idle counter, flags, idle limit register
// depends on igfr_pkg and igfr_ram

module igfr_dp #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  igfr_pkg::cmd_t                cmd,
  output igfr_pkg::status_t             status,
  input  logic [igfr_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic                          cfg_wr_en,
  input  logic [igfr_pkg::IDLE_W-1:0]   cfg_wr_data,
  output logic                          out_strobe,
  output logic                          out_kind,
  output logic [igfr_pkg::BYTE_W-1:0]   out_frame_byte,
  output logic                          out_last_byte,
  output logic                          out_overflowed
);

  import igfr_pkg::*;

  localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

  logic [FILL_W-1:0] fill_r,  fill_nxt;
  logic [IDLE_W-1:0] idle_r,  idle_nxt;
  logic [IDLE_W-1:0] limit_r, limit_nxt;
  logic              ready_r, ready_nxt;
  logic              ovf_r,   ovf_nxt;
  logic              nf_r,    nf_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDLE_W-1:0] idle_inc;
  logic              has_room;
  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign has_room = fill_r < FILL_W'(STORE_DEPTH);
  assign wr_en    = cmd.take_byte && has_room;
  assign idle_inc = (idle_r == IDLE_MAX) ? idle_r : idle_r + 1'b1;

  // read one ahead so the byte is in the read register when it is shown
  assign rd_addr = cmd.stream_en ? rd_idx_r + 1'b1 : '0;

  igfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (in_rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign status.frame_ready = ready_r;
  assign status.last_idx    = (FILL_W'(rd_idx_r) + 1'b1) == fill_r;

  always_comb begin
    fill_nxt   = fill_r;
    idle_nxt   = idle_r;
    ready_nxt  = ready_r;
    ovf_nxt    = ovf_r;
    rd_idx_nxt = rd_idx_r;
    limit_nxt  = cfg_wr_en ? cfg_wr_data : limit_r;
    nf_nxt     = cmd.no_frame;
    if (cmd.take_byte) begin
      idle_nxt = '0;
      if (has_room) begin
        fill_nxt = fill_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.take_tick) begin
      idle_nxt = idle_inc;
      if (fill_r != '0 && idle_inc >= limit_r) begin
        ready_nxt = 1'b1;
      end
    end
    if (cmd.stream_en) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
    if (cmd.stream_done) begin
      rd_idx_nxt = '0;
      fill_nxt   = '0;
      ready_nxt  = 1'b0;
      ovf_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      idle_r   <= '0;
      limit_r  <= IDLE_LIMIT_RESET;
      ready_r  <= 1'b0;
      ovf_r    <= 1'b0;
      nf_r     <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      idle_r   <= idle_nxt;
      limit_r  <= limit_nxt;
      ready_r  <= ready_nxt;
      ovf_r    <= ovf_nxt;
      nf_r     <= nf_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  assign out_strobe     = cmd.stream_en || nf_r;
  assign out_kind       = cmd.stream_en;
  assign out_frame_byte = cmd.stream_en ? rd_data : '0;
  assign out_last_byte  = cmd.stream_en && status.last_idx;
  assign out_overflowed = ovf_r;

endmodule

// ===== design/idle_gap_frame_receiver.sv =====
// top level of the idle-gap frame receiver
// depends on igfr_pkg, igfr_ctrl, igfr_dp (which holds igfr_ram)

// usage
// - input channel: an item (in_operation, in_rx_byte) is a transaction taken
//   at a rising edge with start high and busy low
//   operations: received byte, timer tick, fetch frame request
// - byte and tick transactions finish in the accepting cycle and give no
//   result; busy stays low, so one may follow every cycle
// - fetch with no frame ready: one 'no frame' result (out_kind low) in the
//   cycle after the accept; busy stays low
// - fetch of a ready frame: busy is high while the frame bytes stream out
//   one per cycle from the next cycle on, last one marked; the single read
//   port of the frame store gives one byte read a cycle, read one ahead
// - results carry out_strobe for exactly one cycle; the receiver cannot
//   stall, so every strobed result is taken
// - cfg_wr_en / cfg_wr_data write the idle limit; write only while idle
// - reset (rst_n low, synchronous): empty store, idle count and flags
//   cleared, idle limit back to 10; store contents are left as they are

module idle_gap_frame_receiver #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [igfr_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                        cfg_wr_en,
  input  logic [igfr_pkg::IDLE_W-1:0] cfg_wr_data,
  output logic                        out_strobe,
  output logic                        out_kind,
  output logic [igfr_pkg::BYTE_W-1:0] out_frame_byte,
  output logic                        out_last_byte,
  output logic                        out_overflowed
);

  import igfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller: transaction accept and the streaming sequence
  igfr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  // datapath: store, counters, flags and result drive
  igfr_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_rx_byte     (in_rx_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_strobe     (out_strobe),
    .out_kind       (out_kind),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .out_overflowed (out_overflowed)
  );

endmodule

// ===== design/igfr_checker.sv =====
// port-level checker for the idle-gap frame receiver, bound to the top level
// depends on igfr_pkg and idle_gap_frame_receiver

module igfr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  in_operation,
  input logic                        out_strobe,
  input logic                        out_kind,
  input logic [igfr_pkg::BYTE_W-1:0] out_frame_byte,
  input logic                        out_last_byte,
  input logic                        out_overflowed
);

  import igfr_pkg::*;

  // a no-frame result carries zero byte and no last mark
  a_no_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_kind |-> out_frame_byte == '0 && !out_last_byte)
    else $error("no-frame result with byte or last mark");

  // streaming starts with a frame byte in the first busy cycle
  a_stream_starts: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> out_strobe && out_kind)
    else $error("busy without frame byte");

  // the last byte ends the busy period
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind && out_last_byte |=> !busy)
    else $error("still busy after last byte");

  // frame bytes run back to back with a steady overflow mark until the last
  a_stream_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind && !out_last_byte |=>
      out_strobe && out_kind && $stable(out_overflowed))
    else $error("frame stream broken");

  // byte and tick transactions never make the block busy
  a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation != OP_FETCH |=> !busy)
    else $error("busy after non-fetch transaction");

endmodule

bind idle_gap_frame_receiver igfr_checker u_igfr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_operation   (in_operation),
  .out_strobe     (out_strobe),
  .out_kind       (out_kind),
  .out_frame_byte (out_frame_byte),
  .out_last_byte  (out_last_byte),
  .out_overflowed (out_overflowed)
);

// ===== tb/igfr_checker.sv =====
`timescale 1ns / 1ps
// checker for the idle-gap frame receiver: watches both channels and the idle limit
// write, predicts each fetch result and compares it field by field; depends on igfr_pkg

module igfr_scoreboard #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [igfr_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                        cfg_wr_en,
  input  logic [igfr_pkg::IDLE_W-1:0] cfg_wr_data,
  input  logic                        out_strobe,
  input  logic                        out_kind,
  input  logic [igfr_pkg::BYTE_W-1:0] out_frame_byte,
  input  logic                        out_last_byte,
  input  logic                        out_overflowed,
  output int                          fail_count,
  output int                          pending,
  output int                          frames_seen,
  output int                          bytes_seen,
  output int                          empty_seen
);

  import igfr_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              ovf;
  } frame_out_t;

  // own copy of the receiver state
  logic [BYTE_W-1:0] held_bytes [STORE_DEPTH];
  int unsigned       held_count;
  logic [IDLE_W-1:0] quiet_ticks;
  logic              frame_done;
  logic              dropped;
  logic [IDLE_W-1:0] quiet_limit;

  frame_out_t awaited_out [$];
  int errors, n_frames, n_bytes, n_empty;

  initial begin
    errors   = 0;
    n_frames = 0;
    n_bytes  = 0;
    n_empty  = 0;
  end

  task automatic absorb_item(input op_t op, input logic [BYTE_W-1:0] rx);
    frame_out_t r;
    case (op)
      OP_BYTE: begin
        if (held_count < STORE_DEPTH) begin
          held_bytes[held_count] = rx;
          held_count++;
        end else begin
          dropped = 1'b1;
        end
        quiet_ticks = '0;
      end
      OP_TICK: begin
        if (quiet_ticks != IDLE_MAX) quiet_ticks++;
        if (held_count > 0 && quiet_ticks >= quiet_limit) frame_done = 1'b1;
      end
      OP_FETCH: begin
        if (frame_done && held_count > 0) begin
          for (int unsigned i = 0; i < held_count; i++) begin
            r.kind  = 1'b1;
            r.value = held_bytes[i];
            r.last  = (i + 1 == held_count);
            r.ovf   = dropped;
            awaited_out.push_back(r);
          end
          held_count = 0;
          frame_done = 1'b0;
          dropped    = 1'b0;
        end else begin
          r = '{kind: 1'b0, value: '0, last: 1'b0, ovf: dropped};
          awaited_out.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    frame_out_t want;
    if (awaited_out.size() == 0) begin
      errors++;
      if (errors <= 50)
        $display("%0t: unexpected result kind=%0b byte=%02h last=%0b ovf=%0b", $time,
                 out_kind, out_frame_byte, out_last_byte, out_overflowed);
    end else begin
      want = awaited_out.pop_front();
      if (out_kind !== want.kind || out_frame_byte !== want.value ||
          out_last_byte !== want.last || out_overflowed !== want.ovf) begin
        errors++;
        if (errors <= 50)
          $display({"%0t: mismatch expected kind=%0b byte=%02h last=%0b ovf=%0b,",
                    " got kind=%0b byte=%02h last=%0b ovf=%0b"},
                   $time, want.kind, want.value, want.last, want.ovf,
                   out_kind, out_frame_byte, out_last_byte, out_overflowed);
      end
      if (!want.kind) n_empty++;
      else begin
        n_bytes++;
        if (want.last) n_frames++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count  = 0;
      quiet_ticks = '0;
      frame_done  = 1'b0;
      dropped     = 1'b0;
      quiet_limit = IDLE_LIMIT_RESET;
      awaited_out.delete();
    end else begin
      if (out_strobe) check_result();
      if (cfg_wr_en) quiet_limit = cfg_wr_data;
      if (start && !busy) absorb_item(op_t'(in_operation), in_rx_byte);
    end
    fail_count  <= errors;
    pending     <= awaited_out.size();
    frames_seen <= n_frames;
    bytes_seen  <= n_bytes;
    empty_seen  <= n_empty;
  end

endmodule

// ===== tb/idle_gap_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// top of the idle-gap frame receiver testbench: clock, reset, stimulus and verdict
// depends on igfr_pkg, igfr_scoreboard and the idle_gap_frame_receiver design

module idle_gap_frame_receiver_tb;

  import igfr_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int          CYCLE_LIMIT = 200000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_operation;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              cfg_wr_en;
  logic [IDLE_W-1:0] cfg_wr_data;
  logic              out_strobe;
  logic              out_kind;
  logic [BYTE_W-1:0] out_frame_byte;
  logic              out_last_byte;
  logic              out_overflowed;

  int fail_count, pending, frames_seen, bytes_seen, empty_seen;
  int items_sent  = 0;
  int idle_pct    = 0;
  int cycle_count = 0;

  idle_gap_frame_receiver #(.STORE_DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_rx_byte     (in_rx_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_strobe     (out_strobe),
    .out_kind       (out_kind),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .out_overflowed (out_overflowed)
  );

  igfr_scoreboard #(.STORE_DEPTH(DEPTH)) u_scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_rx_byte     (in_rx_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_strobe     (out_strobe),
    .out_kind       (out_kind),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .out_overflowed (out_overflowed),
    .fail_count     (fail_count),
    .pending        (pending),
    .frames_seen    (frames_seen),
    .bytes_seen     (bytes_seen),
    .empty_seen     (empty_seen)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: far above the slowest legal run (every fetch streaming a full
  // store, every transaction followed by the longest sender gap)
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results still due", cycle_count, pending);
      $display("FAIL idle_gap_frame_receiver");
      $finish;
    end
  end

  // one transaction: hold start and the fields until the edge where busy is low,
  // then maybe leave a gap with start low and junk on the fields
  task automatic send_item(input op_t op, input logic [BYTE_W-1:0] rx);
    start        <= 1'b1;
    in_operation <= op;
    in_rx_byte   <= rx;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_NONE) items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start        <= 1'b0;
      in_operation <= 2'($urandom_range(3));
      in_rx_byte   <= 8'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every due result, then let a fetch tail settle;
  // the checker's count is registered, hence the lead-in before the wait
  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // idle limit writes happen only on a drained block
  task automatic set_idle_limit(input logic [IDLE_W-1:0] limit);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 8'($urandom);
  endtask

  // random part: mostly whole frames (burst of bytes, ticks around the limit,
  // fetch) with random content, the rest single random transactions as noise
  task automatic run_random(input logic [IDLE_W-1:0] limit, input int pct, input int count);
    int goal, n, t;
    goal = items_sent + count;
    set_idle_limit(limit);
    idle_pct = pct;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 70) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 1, DEPTH + 4)
                                     : $urandom_range(1, DEPTH);
        repeat (n) send_item(OP_BYTE, 8'($urandom));
        // sometimes stop short of the limit so the fetch finds no frame
        if (limit > 0 && $urandom_range(99) < 15) t = $urandom_range(0, limit - 1);
        else t = limit + $urandom_range(0, 2);
        repeat (t) send_item(OP_TICK, 8'($urandom));
        // late byte joins a frame that is already complete
        if ($urandom_range(3) == 0) send_item(OP_BYTE, 8'($urandom));
        send_item(OP_FETCH, 8'($urandom));
      end else begin
        send_item(op_t'($urandom_range(3)), 8'($urandom));
      end
      if ($urandom_range(29) == 0) drain();
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_operation <= OP_NONE;
    in_rx_byte   <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset limit of 10: empty fetch, ignored operation, frame that
    // completes on the tenth tick, late byte after completion
    idle_pct = 30;
    send_item(OP_FETCH, 8'h00);
    send_item(OP_NONE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    repeat (9) send_item(OP_TICK, 8'h00);
    send_item(OP_FETCH, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'hA5);
    send_item(OP_FETCH, 8'h00);

    // limit zero: tick on an empty store completes nothing, store overrun
    // raises the overflow flag, visible both on a no-frame result and on the frame
    set_idle_limit(8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_FETCH, 8'h00);
    for (int i = 0; i <= DEPTH; i++) send_item(OP_BYTE, 8'(i * 17 + 3));
    send_item(OP_FETCH, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_FETCH, 8'h00);
    send_item(OP_FETCH, 8'h00);

    // high limit: one tick short gives no frame, the next ticks complete it
    set_idle_limit(8'd60);
    idle_pct = 0;
    send_item(OP_BYTE, 8'h5A);
    repeat (59) send_item(OP_TICK, 8'($urandom));
    send_item(OP_FETCH, 8'h00);
    repeat (2) send_item(OP_TICK, 8'($urandom));
    send_item(OP_FETCH, 8'h00);

    // random phases: back to back, sender mostly idle, sender lightly idle
    run_random(8'd1, 0, 50);
    run_random(8'd5, 62, 50);
    // hold off mid-stream until everything due has come out
    drain();
    run_random(8'd2, 12, 50);

    drain();
    repeat (20) @(posedge clk);

    $display("%0d transactions sent over idle limits 10, 0, 60, 1, 5 and 2", items_sent);
    $display("%0d frames (%0d bytes) and %0d no-frame results checked",
             frames_seen, bytes_seen, empty_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS idle_gap_frame_receiver");
    end else begin
      $display("FAIL idle_gap_frame_receiver");
    end
    $finish;
  end

endmodule
